FILE: rtl/rtta_pkg.sv
// ----------------------------------------------------------------------------
// rtta_pkg
// Shared types, register codes and constants for the rotated tiled texel
// address block.
// ----------------------------------------------------------------------------
`default_nettype none

package rtta_pkg;

  // default widths of the coordinate path
  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 14;

  // fixed field widths
  localparam int unsigned SCREEN_W   = 16;
  localparam int unsigned FIELD_W    = 16;
  localparam int unsigned TEXEL_W    = 15;
  localparam int unsigned PROD_W     = 2 * TEXEL_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // register stages of the rotation front end
  localparam int unsigned ROT_STAGES = 5;

  localparam logic signed [FIELD_W-1:0] COS_RESET = 16'sd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROTATE_ENABLE = 3'd0,
    REG_CENTER_X      = 3'd1,
    REG_CENTER_Y      = 3'd2,
    REG_COS_Q14       = 3'd3,
    REG_SIN_Q14       = 3'd4,
    REG_X_AXIS        = 3'd5,
    REG_Y_AXIS        = 3'd6
  } cfg_reg_e;

  // one axis register, most significant field first
  typedef struct packed {
    logic signed [FIELD_W-1:0] inv;
    logic signed [FIELD_W-1:0] src;
    logic signed [FIELD_W-1:0] per;
    logic signed [FIELD_W-1:0] off;
  } axis_cfg_t;

  typedef struct packed {
    logic                      en;
    logic signed [FIELD_W-1:0] cx;
    logic signed [FIELD_W-1:0] cy;
    logic signed [FIELD_W-1:0] cs;
    logic signed [FIELD_W-1:0] sn;
  } rot_cfg_t;

endpackage

`default_nettype wire

FILE: rtl/rtta_div.sv
// ----------------------------------------------------------------------------
// rtta_div
// Pipelined restoring divider, one quotient bit per stage, with a valid bit
// and a sideband word carried along each stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rtta_div #(
  parameter int unsigned NumW  = 17,
  parameter int unsigned DenW  = 16,
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [NumW-1:0]  quo_o,
  output logic [DenW-1:0]  rem_o,
  output logic [SideW-1:0] side_o
);

  logic             vld_q  [NumW];
  logic [DenW-1:0]  rem_q  [NumW];
  logic [NumW-1:0]  nq_q   [NumW];
  logic [SideW-1:0] side_q [NumW];

  for (genvar i = 0; i < NumW; i++) begin : g_step
    logic             vld_in;
    logic [DenW-1:0]  rem_in;
    logic [NumW-1:0]  nq_in;
    logic [SideW-1:0] side_in;
    logic [DenW:0]    trial;
    logic [DenW:0]    diff;
    logic             take;

    if (i == 0) begin : g_head
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign nq_in   = num_i;
      assign side_in = side_i;
    end else begin : g_body
      assign vld_in  = vld_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign nq_in   = nq_q[i-1];
      assign side_in = side_q[i-1];
    end

    // dividend bits leave at the top, quotient bits enter at the bottom
    assign trial = {rem_in, nq_in[NumW-1]};
    assign diff  = trial - {1'b0, den_i};
    assign take  = (trial >= {1'b0, den_i});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i]  <= take ? diff[DenW-1:0] : trial[DenW-1:0];
      nq_q[i]   <= {nq_in[NumW-2:0], take};
      side_q[i] <= side_in;
    end
  end

  assign valid_o = vld_q[NumW-1];
  assign quo_o   = nq_q[NumW-1];
  assign rem_o   = rem_q[NumW-1];
  assign side_o  = side_q[NumW-1];

endmodule

`default_nettype wire

FILE: rtl/rtta_rotate.sv
// ----------------------------------------------------------------------------
// rtta_rotate
// Five-stage rotation of a screen point about a centre with Q-format
// cosine and sine, rounding away from zero, wrapped to the coordinate width.
// ----------------------------------------------------------------------------
`default_nettype none

module rtta_rotate #(
  parameter int unsigned CoordBits = rtta_pkg::COORD_BITS_DEF,
  parameter int unsigned FracBits  = rtta_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic signed [rtta_pkg::SCREEN_W-1:0] x_i,
  input  logic signed [rtta_pkg::SCREEN_W-1:0] y_i,
  input  rtta_pkg::rot_cfg_t                  cfg_i,
  output logic                                valid_o,
  output logic signed [CoordBits-1:0]         x_o,
  output logic signed [CoordBits-1:0]         y_o
);

  import rtta_pkg::*;

  localparam int unsigned DiffW = SCREEN_W + 1;
  localparam int unsigned MulW  = FIELD_W + DiffW;
  localparam int unsigned SumW  = MulW + 1;
  localparam int unsigned RndW  = SumW + 1;
  localparam int unsigned OutW  = RndW + 1;
  localparam logic [RndW-1:0] Half = RndW'(1) << (FracBits - 1);

  logic [ROT_STAGES-1:0] vld_q;

  logic signed [DiffW-1:0]    tx_q, ty_q;
  logic signed [SCREEN_W-1:0] x1_q, y1_q, x2_q, y2_q, x3_q, y3_q, x4_q, y4_q;
  logic signed [MulW-1:0]     pxc_q, pys_q, pxs_q, pyc_q;
  logic signed [SumW-1:0]     fx_q, fy_q;
  logic signed [RndW-1:0]     rx_q, ry_q;
  logic signed [CoordBits-1:0] xo_q, yo_q;

  logic signed [RndW-1:0] shx, shy;
  logic [OutW-1:0]        sumx, sumy, bypx, bypy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[ROT_STAGES-2:0], valid_i};
    end
  end

  // translate to centre, multiply, combine, round, shift back
  always_comb begin
    shx  = rx_q >>> FracBits;
    shy  = ry_q >>> FracBits;
    sumx = {shx[RndW-1], shx} + {{(OutW-FIELD_W){cfg_i.cx[FIELD_W-1]}}, cfg_i.cx};
    sumy = {shy[RndW-1], shy} + {{(OutW-FIELD_W){cfg_i.cy[FIELD_W-1]}}, cfg_i.cy};
    bypx = {{(OutW-SCREEN_W){x4_q[SCREEN_W-1]}}, x4_q};
    bypy = {{(OutW-SCREEN_W){y4_q[SCREEN_W-1]}}, y4_q};
  end

  always_ff @(posedge clk_i) begin
    tx_q  <= {x_i[SCREEN_W-1], x_i} - {cfg_i.cx[FIELD_W-1], cfg_i.cx};
    ty_q  <= {y_i[SCREEN_W-1], y_i} - {cfg_i.cy[FIELD_W-1], cfg_i.cy};
    x1_q  <= x_i;
    y1_q  <= y_i;

    pxc_q <= MulW'(cfg_i.cs) * MulW'(tx_q);
    pys_q <= MulW'(cfg_i.sn) * MulW'(ty_q);
    pxs_q <= MulW'(cfg_i.sn) * MulW'(tx_q);
    pyc_q <= MulW'(cfg_i.cs) * MulW'(ty_q);
    x2_q  <= x1_q;
    y2_q  <= y1_q;

    fx_q  <= {pxc_q[MulW-1], pxc_q} - {pys_q[MulW-1], pys_q};
    fy_q  <= {pxs_q[MulW-1], pxs_q} + {pyc_q[MulW-1], pyc_q};
    x3_q  <= x2_q;
    y3_q  <= y2_q;

    // away from zero
    rx_q  <= fx_q[SumW-1] ? {fx_q[SumW-1], fx_q} - Half : {fx_q[SumW-1], fx_q} + Half;
    ry_q  <= fy_q[SumW-1] ? {fy_q[SumW-1], fy_q} - Half : {fy_q[SumW-1], fy_q} + Half;
    x4_q  <= x3_q;
    y4_q  <= y3_q;

    xo_q  <= cfg_i.en ? sumx[CoordBits-1:0] : bypx[CoordBits-1:0];
    yo_q  <= cfg_i.en ? sumy[CoordBits-1:0] : bypy[CoordBits-1:0];
  end

  assign valid_o = vld_q[ROT_STAGES-1];
  assign x_o     = xo_q;
  assign y_o     = yo_q;

endmodule

`default_nettype wire

FILE: rtl/rtta_axis.sv
// ----------------------------------------------------------------------------
// rtta_axis
// One axis: mirror, offset, floored wrap by the period and scaling by
// source size over period, through two pipelined dividers.
// ----------------------------------------------------------------------------
`default_nettype none

module rtta_axis #(
  parameter int unsigned CoordBits = rtta_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [CoordBits-1:0]       c_i,
  input  rtta_pkg::axis_cfg_t               cfg_i,
  output logic                              valid_o,
  output logic [rtta_pkg::TEXEL_W-1:0]      texel_o
);

  import rtta_pkg::*;

  localparam int unsigned ExtW = ((CoordBits > FIELD_W) ? CoordBits : FIELD_W) + 1;

  logic                       v1_q, v2_q, v3_q, v4_q, v5_q;
  logic signed [CoordBits-1:0] c1_q;
  logic [ExtW-1:0]            mag_q;
  logic                       neg_q;
  logic [TEXEL_W-1:0]         m_q;
  logic [PROD_W-1:0]          prod_q;
  logic                       ok_q;
  logic [TEXEL_W-1:0]         texel_q;

  logic [ExtW-1:0]    cext, c1ext, invext, offext, mir, dif;
  logic               mod_vld, scl_vld, mod_neg, scl_ok;
  logic [FIELD_W-1:0] mod_rem, scl_rem;
  logic [ExtW-1:0]    mod_quo;
  logic [PROD_W-1:0]  scl_quo;
  logic [TEXEL_W-1:0] r;

  always_comb begin
    cext   = {{(ExtW-CoordBits){c_i[CoordBits-1]}}, c_i};
    c1ext  = {{(ExtW-CoordBits){c1_q[CoordBits-1]}}, c1_q};
    invext = {{(ExtW-FIELD_W){cfg_i.inv[FIELD_W-1]}}, cfg_i.inv};
    offext = {{(ExtW-FIELD_W){cfg_i.off[FIELD_W-1]}}, cfg_i.off};
    mir    = invext - cext;
    dif    = c1ext - offext;
    r      = mod_rem[TEXEL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= mod_vld;
      v4_q <= v3_q;
      v5_q <= scl_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    // invert of zero leaves the axis unmirrored
    c1_q  <= (cfg_i.inv != '0) ? mir[CoordBits-1:0] : c_i;
    neg_q <= dif[ExtW-1];
    mag_q <= dif[ExtW-1] ? (~dif + ExtW'(1)) : dif;
    // floored modulo from the magnitude remainder
    m_q   <= (mod_neg && (mod_rem != '0)) ? (cfg_i.per[TEXEL_W-1:0] - r) : r;
    prod_q <= PROD_W'(m_q) * PROD_W'(cfg_i.src[TEXEL_W-1:0]);
    ok_q  <= (cfg_i.per > 16'sd0) && (cfg_i.src > 16'sd0);
    texel_q <= scl_ok ? scl_quo[TEXEL_W-1:0] : '0;
  end

  rtta_div #(
    .NumW  (ExtW),
    .DenW  (FIELD_W),
    .SideW (1)
  ) u_mod_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_q),
    .num_i   (mag_q),
    .den_i   (cfg_i.per),
    .side_i  (neg_q),
    .valid_o (mod_vld),
    .quo_o   (mod_quo),
    .rem_o   (mod_rem),
    .side_o  (mod_neg)
  );

  rtta_div #(
    .NumW  (PROD_W),
    .DenW  (FIELD_W),
    .SideW (1)
  ) u_scale_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v4_q),
    .num_i   (prod_q),
    .den_i   (cfg_i.per),
    .side_i  (ok_q),
    .valid_o (scl_vld),
    .quo_o   (scl_quo),
    .rem_o   (scl_rem),
    .side_o  (scl_ok)
  );

  assign valid_o = v5_q;
  assign texel_o = texel_q;

endmodule

`default_nettype wire

FILE: rtl/rotated_tiled_texel_address.sv
// ----------------------------------------------------------------------------
// rotated_tiled_texel_address
// Maps a screen pixel to the texel of a tiled, optionally rotated and
// mirrored source image.
// ----------------------------------------------------------------------------
// Usage: drive screen_x_i/screen_y_i with start high; busy stays low, so a
// coordinate transfers on every clock. Each result appears on texel_x_o and
// texel_y_o for one cycle with done_o high, in input order.
// Pipeline: 5 rotation stages, mirror and offset stages, a modulo divider of
// one bit per stage over the offset coordinate, a fix-up and a multiply
// stage, a 30-stage scaling divider and the output register. Throughput is
// one pixel per clock.
// Configuration: cfg_we_i writes register cfg_idx_i at the clock edge; write
// only while no pixel is in flight. Indexes past the last register are
// ignored.
// Reset clears all configuration registers to their defaults and drops every pixel in
// flight. The receiver cannot stall: done_o is a one-cycle strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module rotated_tiled_texel_address #(
  parameter int unsigned COORD_BITS = rtta_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = rtta_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [rtta_pkg::SCREEN_W-1:0] screen_x_i,
  input  logic signed [rtta_pkg::SCREEN_W-1:0] screen_y_i,
  output logic                                 done_o,
  output logic [rtta_pkg::TEXEL_W-1:0]         texel_x_o,
  output logic [rtta_pkg::TEXEL_W-1:0]         texel_y_o,
  input  logic                                 cfg_we_i,
  input  logic [rtta_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rtta_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  import rtta_pkg::*;

  localparam int unsigned ExtW    = ((COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W) + 1;
  localparam int unsigned Latency = ROT_STAGES + 2 + ExtW + 2 + PROD_W + 1;

  logic                      rot_en_q;
  logic signed [FIELD_W-1:0] cx_q, cy_q, cos_q, sin_q;
  axis_cfg_t                 xaxis_q, yaxis_q;
  rot_cfg_t                  rot_cfg;

  logic                        accept, rot_vld, x_vld, y_vld;
  logic signed [COORD_BITS-1:0] rot_x, rot_y;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_en_q <= 1'b0;
      cx_q     <= '0;
      cy_q     <= '0;
      cos_q    <= COS_RESET;
      sin_q    <= '0;
      xaxis_q  <= '0;
      yaxis_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROTATE_ENABLE: rot_en_q <= cfg_data_i[0];
        REG_CENTER_X:      cx_q     <= cfg_data_i[FIELD_W-1:0];
        REG_CENTER_Y:      cy_q     <= cfg_data_i[FIELD_W-1:0];
        REG_COS_Q14:       cos_q    <= cfg_data_i[FIELD_W-1:0];
        REG_SIN_Q14:       sin_q    <= cfg_data_i[FIELD_W-1:0];
        REG_X_AXIS:        xaxis_q  <= cfg_data_i;
        REG_Y_AXIS:        yaxis_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    rot_cfg.en = rot_en_q;
    rot_cfg.cx = cx_q;
    rot_cfg.cy = cy_q;
    rot_cfg.cs = cos_q;
    rot_cfg.sn = sin_q;
  end

  rtta_rotate #(
    .CoordBits (COORD_BITS),
    .FracBits  (FRAC_BITS)
  ) u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .x_i     (screen_x_i),
    .y_i     (screen_y_i),
    .cfg_i   (rot_cfg),
    .valid_o (rot_vld),
    .x_o     (rot_x),
    .y_o     (rot_y)
  );

  rtta_axis #(
    .CoordBits (COORD_BITS)
  ) u_axis_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rot_vld),
    .c_i     (rot_x),
    .cfg_i   (xaxis_q),
    .valid_o (x_vld),
    .texel_o (texel_x_o)
  );

  rtta_axis #(
    .CoordBits (COORD_BITS)
  ) u_axis_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rot_vld),
    .c_i     (rot_y),
    .cfg_i   (yaxis_q),
    .valid_o (y_vld),
    .texel_o (texel_y_o)
  );

  assign done_o = x_vld;

  // both axis pipelines must stay in lockstep
  a_axes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    x_vld == y_vld)
    else $error("x and y axis pipelines out of step");

  // every result comes from a transfer exactly one latency earlier
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Latency))
    else $error("result without a matching input transfer");

  // rotation stage output always precedes the axis results by the axis depth
  a_rot_feeds_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(rot_vld, Latency - ROT_STAGES))
    else $error("result without a rotated coordinate behind it");

endmodule

`default_nettype wire

FILE: verif/rotated_tiled_texel_address_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotated_tiled_texel_address_tb
// Drives screen coordinates into the texel address block and checks every
// returned texel against a typed table value or an in-bench predictor of the
// rotate, mirror, wrap and scale path. A directed table covers field extremes,
// rounding ties, mirroring and degenerate axes; random settings and
// coordinates follow with varying sender idle rates.
// ----------------------------------------------------------------------------
module rotated_tiled_texel_address_tb;
  import rtta_pkg::*;

  localparam int unsigned CLK_HALF      = 4;
  localparam int unsigned RESET_CYCLES  = 8;
  localparam int unsigned TAIL_CYCLES   = 64;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned RANDOM_BLOCKS = 12;
  localparam int unsigned BLOCK_ITEMS   = 96;
  localparam int unsigned NUM_SETTINGS  = 9;
  localparam int unsigned NUM_ROWS      = 23;
  localparam int unsigned MAX_PRINTS    = 50;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    rot_cfg_t  rot;
    axis_cfg_t xa;
    axis_cfg_t ya;
  } tex_cfg_t;

  typedef struct packed {
    logic [TEXEL_W-1:0] tx;
    logic [TEXEL_W-1:0] ty;
  } texel_t;

  typedef struct packed {
    logic [3:0]          setting;
    logic [SCREEN_W-1:0] sx;
    logic [SCREEN_W-1:0] sy;
    logic                typed;
    texel_t              want;
  } stim_row_t;

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  start    = 1'b0;
  logic                  busy;
  logic [SCREEN_W-1:0]   screen_x = '0;
  logic [SCREEN_W-1:0]   screen_y = '0;
  logic                  done;
  logic [TEXEL_W-1:0]    texel_x;
  logic [TEXEL_W-1:0]    texel_y;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  tex_cfg_t  cur_cfg;
  tex_cfg_t  settings [NUM_SETTINGS];
  stim_row_t dir_rows [NUM_ROWS];
  texel_t    pending_texels [$];
  int        error_count = 0;
  int        cycle_count = 0;

  rotated_tiled_texel_address dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start      (start),
    .busy       (busy),
    .screen_x_i (screen_x),
    .screen_y_i (screen_y),
    .done_o     (done),
    .texel_x_o  (texel_x),
    .texel_y_o  (texel_y),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic longint wrap_coord(input longint v);
    logic signed [COORD_BITS_DEF-1:0] t;
    t = v[COORD_BITS_DEF-1:0];
    return longint'(t);
  endfunction

  // ties go away from zero
  function automatic longint round_frac(input longint f);
    longint half;
    half = longint'(1) << (FRAC_BITS_DEF - 1);
    if (f < 0) return (f - half) >>> FRAC_BITS_DEF;
    return (f + half) >>> FRAC_BITS_DEF;
  endfunction

  function automatic logic [TEXEL_W-1:0] wrap_axis(input longint c, input axis_cfg_t a);
    longint coord, off, per, src, inv, m;
    coord = c;
    off   = longint'(a.off);
    per   = longint'(a.per);
    src   = longint'(a.src);
    inv   = longint'(a.inv);
    if (inv != 0) coord = wrap_coord(inv - coord);
    if (per <= 0 || src <= 0) return '0;
    // floored modulo
    m = (coord - off) % per;
    if (m < 0) m += per;
    return TEXEL_W'((m * src) / per);
  endfunction

  function automatic texel_t predict_texel(input logic [SCREEN_W-1:0] sxv,
                                           input logic [SCREEN_W-1:0] syv);
    longint x, y, cx, cy, cs, sn, tx, ty;
    texel_t r;
    x = wrap_coord(longint'($signed(sxv)));
    y = wrap_coord(longint'($signed(syv)));
    if (cur_cfg.rot.en) begin
      cx = longint'(cur_cfg.rot.cx);
      cy = longint'(cur_cfg.rot.cy);
      cs = longint'(cur_cfg.rot.cs);
      sn = longint'(cur_cfg.rot.sn);
      tx = x - cx;
      ty = y - cy;
      x  = wrap_coord(round_frac(cs * tx - sn * ty) + cx);
      y  = wrap_coord(round_frac(sn * tx + cs * ty) + cy);
    end
    r.tx = wrap_axis(x, cur_cfg.xa);
    r.ty = wrap_axis(y, cur_cfg.ya);
    return r;
  endfunction

  // ------------------------------------------------------------ table helpers

  function automatic axis_cfg_t axis_of(input int off, input int per, input int src,
                                        input int inv);
    axis_cfg_t a;
    a.off = FIELD_W'(off);
    a.per = FIELD_W'(per);
    a.src = FIELD_W'(src);
    a.inv = FIELD_W'(inv);
    return a;
  endfunction

  function automatic rot_cfg_t rot_of(input bit en, input int cx, input int cy,
                                      input int cs, input int sn);
    rot_cfg_t r;
    r.en = en;
    r.cx = FIELD_W'(cx);
    r.cy = FIELD_W'(cy);
    r.cs = FIELD_W'(cs);
    r.sn = FIELD_W'(sn);
    return r;
  endfunction

  function automatic stim_row_t row(input int s, input int x, input int y,
                                    input bit typed = 1'b0, input int wx = 0,
                                    input int wy = 0);
    stim_row_t r;
    r.setting = 4'(s);
    r.sx      = SCREEN_W'(x);
    r.sy      = SCREEN_W'(y);
    r.typed   = typed;
    r.want.tx = TEXEL_W'(wx);
    r.want.ty = TEXEL_W'(wy);
    return r;
  endfunction

  // --------------------------------------------------------- random helpers

  function automatic logic [SCREEN_W-1:0] pick_coord();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return SCREEN_W'($urandom);
    endcase
  endfunction

  function automatic logic [FIELD_W-1:0] pick_trig();
    int v;
    case ($urandom_range(5))
      0: v = 16384;
      1: v = -16384;
      2: v = 0;
      default: v = int'($urandom_range(32768)) - 16384;
    endcase
    return v[FIELD_W-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] pick_size();
    int v;
    case ($urandom_range(19))
      0: v = -int'($urandom_range(32768));
      1: v = 32767;
      2: v = $urandom_range(32767);
      default: v = $urandom_range(1, 256);
    endcase
    return v[FIELD_W-1:0];
  endfunction

  function automatic axis_cfg_t random_axis();
    axis_cfg_t a;
    a.off = FIELD_W'($urandom);
    a.per = pick_size();
    a.src = pick_size();
    a.inv = ($urandom_range(1) == 0) ? '0 : pick_coord();
    return a;
  endfunction

  function automatic tex_cfg_t random_setting();
    tex_cfg_t c;
    c.rot.en = 1'($urandom_range(1));
    c.rot.cx = pick_coord();
    c.rot.cy = pick_coord();
    c.rot.cs = pick_trig();
    c.rot.sn = pick_trig();
    c.xa     = random_axis();
    c.ya     = random_axis();
    return c;
  endfunction

  function automatic logic [SCREEN_W-1:0] random_screen();
    logic [SCREEN_W-1:0] v;
    v = SCREEN_W'($urandom);
    if ($urandom_range(3) == 0) v = pick_coord();
    return v;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want,
               cycle_count);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic load_config(input tex_cfg_t c);
    logic [CFG_DATA_W-1:0] junk;
    junk = {$urandom, $urandom};
    // unused upper bits carry junk
    put_reg(REG_ROTATE_ENABLE, {junk[63:1], c.rot.en});
    put_reg(REG_CENTER_X, {junk[63:16], c.rot.cx});
    put_reg(REG_CENTER_Y, {junk[63:16], c.rot.cy});
    put_reg(REG_COS_Q14, {junk[63:16], c.rot.cs});
    put_reg(REG_SIN_Q14, {junk[63:16], c.rot.sn});
    put_reg(REG_X_AXIS, c.xa);
    put_reg(REG_Y_AXIS, c.ya);
    // an out-of-range index must leave every register alone
    put_reg(REG_UNUSED, junk);
    cfg_we  <= 1'b0;
    cur_cfg = c;
  endtask

  task automatic send_pixel(input logic [SCREEN_W-1:0] xv, input logic [SCREEN_W-1:0] yv,
                            input bit typed, input texel_t want);
    start    <= 1'b1;
    screen_x <= xv;
    screen_y <= yv;
    do @(posedge clk); while (busy);
    pending_texels.push_back(typed ? want : predict_texel(xv, yv));
  endtask

  task automatic sender_gap(input int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < pct);
    end
  endtask

  // every transfer gives exactly one result, so an empty queue means idle
  task automatic drain();
    start <= 1'b0;
    while (pending_texels.size() != 0) @(posedge clk);
  endtask

  // ------------------------------------------------------------------ check

  always @(posedge clk) begin
    texel_t want;
    if (rst_n && done) begin
      if (pending_texels.size() == 0) begin
        report_mismatch("result with nothing pending, texel_x", int'(texel_x), 0);
      end else begin
        want = pending_texels.pop_front();
        if (texel_x !== want.tx)
          report_mismatch("texel_x", int'(texel_x), int'(want.tx));
        if (texel_y !== want.ty)
          report_mismatch("texel_y", int'(texel_y), int'(want.ty));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------- stimulus

  initial begin
    int last_setting;
    int gap_pct;

    settings[0] = {rot_of(1'b0, 0, 0, COS_RESET, 0), axis_of(0, 0, 0, 0),
                   axis_of(0, 0, 0, 0)};
    settings[1] = {rot_of(1'b0, 0, 0, COS_RESET, 0), axis_of(0, 64, 64, 0),
                   axis_of(0, 64, 64, 0)};
    // mirrored axes
    settings[2] = {rot_of(1'b0, 0, 0, COS_RESET, 0), axis_of(3, 64, 64, 100),
                   axis_of(0, 64, 64, -1)};
    // mirror that wraps the coordinate, extreme offset
    settings[3] = {rot_of(1'b0, 0, 0, COS_RESET, 0), axis_of(0, 32767, 32767, 32767),
                   axis_of(32767, 32767, 32767, -32768)};
    // non-positive period or source size
    settings[4] = {rot_of(1'b0, 0, 0, COS_RESET, 0), axis_of(0, -5, 10, 0),
                   axis_of(0, 10, 0, 0)};
    // stretched axes
    settings[5] = {rot_of(1'b0, 0, 0, COS_RESET, 0), axis_of(-50, 100, 37, 0),
                   axis_of(0, 1, 32767, 0)};
    // tiny cosine puts rounding ties on the half
    settings[6] = {rot_of(1'b1, 0, 0, 1, 0), axis_of(0, 32767, 32767, 0),
                   axis_of(0, 32767, 32767, 0)};
    settings[7] = {rot_of(1'b1, 10, -20, 0, 16384), axis_of(0, 32767, 32767, 0),
                   axis_of(0, 32767, 32767, 0)};
    settings[8] = {rot_of(1'b1, -32768, 32767, -16384, 16384),
                   axis_of(-32768, 32767, 32767, -32768), axis_of(32767, 1000, 32767, 0)};

    dir_rows[0]  = row(0, 0, 0, 1'b1, 0, 0);
    dir_rows[1]  = row(0, -32768, 32767, 1'b1, 0, 0);
    dir_rows[2]  = row(1, 5, 7, 1'b1, 5, 7);
    dir_rows[3]  = row(1, -1, -64, 1'b1, 63, 0);
    dir_rows[4]  = row(1, 32767, -32768, 1'b1, 63, 0);
    dir_rows[5]  = row(1, 64, 65, 1'b1, 0, 1);
    dir_rows[6]  = row(2, 0, 0);
    dir_rows[7]  = row(2, 100, -1);
    dir_rows[8]  = row(2, -32768, 32767);
    dir_rows[9]  = row(3, -32768, 32767);
    dir_rows[10] = row(3, 32767, -32768);
    dir_rows[11] = row(4, 123, -456, 1'b1, 0, 0);
    dir_rows[12] = row(4, -32768, 32767, 1'b1, 0, 0);
    dir_rows[13] = row(5, -50, 0, 1'b1, 0, 0);
    dir_rows[14] = row(5, 49, 12345);
    dir_rows[15] = row(5, -32768, 32767);
    dir_rows[16] = row(6, 8192, -8192);
    dir_rows[17] = row(6, 8191, -8191);
    dir_rows[18] = row(6, -32768, 32767);
    dir_rows[19] = row(7, 10, -20);
    dir_rows[20] = row(7, 0, 0);
    dir_rows[21] = row(8, 32767, -32768);
    dir_rows[22] = row(8, -32768, 32767);

    cur_cfg = settings[0];
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    last_setting = 0;
    foreach (dir_rows[i]) begin
      if (int'(dir_rows[i].setting) != last_setting) begin
        drain();
        load_config(settings[dir_rows[i].setting]);
        last_setting = int'(dir_rows[i].setting);
      end
      send_pixel(dir_rows[i].sx, dir_rows[i].sy, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int b = 0; b < RANDOM_BLOCKS; b++) begin
      gap_pct = (b % 3 == 1) ? 87 : (b % 3 == 2) ? 13 : 0;
      drain();
      load_config(random_setting());
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        send_pixel(random_screen(), random_screen(), 1'b0, '0);
        sender_gap(gap_pct);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_texels.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/rtta_pkg.sv
rtl/rtta_div.sv
rtl/rtta_rotate.sv
rtl/rtta_axis.sv
rtl/rotated_tiled_texel_address.sv
verif/rotated_tiled_texel_address_tb.sv
